// ----- hdl/mtse_pkg.sv -----
// ============================================================================
// mtse_pkg - shared types and constants of the multitouch slot event generator
// Holds the item layout, operation codes and event kinds used by the block
// and by its port checker.
// ============================================================================
`default_nettype none

package mtse_pkg;

    // field widths of one input item and one result item
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 4;
    localparam int COORD_W  = 12;
    localparam int VALUE_W  = 17;
    localparam int TRACK_W  = 16;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 24;

    // operation codes
    localparam logic [OP_W-1:0] OP_TOUCH       = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE     = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE_ALL = 2'd2;

    // event kinds carried in the low bits of each output beat
    typedef enum logic [2:0] {
        EV_SLOT   = 3'd0,
        EV_TRACK  = 3'd1,
        EV_MTX    = 3'd2,
        EV_MTY    = 3'd3,
        EV_BUTTON = 3'd4,
        EV_SX     = 3'd5,
        EV_SY     = 3'd6,
        EV_SYNC   = 3'd7
    } kind_t;

endpackage

`default_nettype wire

// ----- hdl/mtse_ram.sv -----
// ============================================================================
// mtse_ram - generic single-clock RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module mtse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  wire logic                                 clk,
    input  wire logic                                 wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                     wr_data,
    input  wire logic                                 rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/multitouch_slot_event_generator.sv -----
// ============================================================================
// multitouch_slot_event_generator - touch slot table and event sequencer
// Takes one touch record per input beat (touch at a position, release one
// slot, or release all slots) and emits the slot-protocol event beats it
// causes, one beat per cycle while the sink is ready, tlast on the final
// one. The tracking id of each slot lives in a small RAM that is read,
// updated and written back per slot; a row of valid bits makes every slot
// read as free after reset, so no clearing pass is needed. One item is
// handled at a time: a touch or a release is accepted, its slot is read
// from the RAM and its event beats are then emitted; release-all reads the
// slots in turn, emits the beats of each occupied one, and stops after the
// last occupied slot. The pace is set by the read-modify-write of the slot
// RAM, the one-beat-per-cycle output and stalls of the sink. Items naming a
// slot at or above SLOTS, unused operation codes, releases of free slots
// and release-all with no finger down produce no beats.
// ============================================================================
`default_nettype none

module multitouch_slot_event_generator
    import mtse_pkg::*;
#(
    parameter int SLOTS       = 10,
    parameter int TRACK_LIMIT = 65535
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input beat: operation[1:0], slot[5:2], x[17:6], y[29:18], zeros[31:30]
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,
    // output beat: event_kind[2:0], event_value[19:3], zeros[23:20]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [OUT_W-1:0]  m_tdata,
    output logic                   m_tlast
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [AW-1:0]      LAST_IDX  = AW'(SLOTS - 1);
    localparam logic [SLOT_W:0]    SLOT_LIM  = (SLOT_W + 1)'(SLOTS);
    localparam logic [TRACK_W-1:0] TRACK_TOP = TRACK_W'(TRACK_LIMIT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [OP_W-1:0]     op_reg;
    logic [AW-1:0]       idx_reg;
    logic [COORD_W-1:0]  x_reg;
    logic [COORD_W-1:0]  y_reg;
    logic [TRACK_W-1:0]  id_reg;
    logic [TRACK_W-1:0]  next_track_reg;
    logic [CW-1:0]       count_reg;
    logic [SLOTS-1:0]    valid_reg;
    logic                fresh_reg;
    logic                button_reg;
    logic                single_reg;
    kind_t               kind_reg;

    // input beat fields
    logic [OP_W-1:0]     in_op;
    logic [SLOT_W-1:0]   in_slot;
    logic [COORD_W-1:0]  in_x;
    logic [COORD_W-1:0]  in_y;

    // ram ports
    logic                ram_wr_en;
    logic [TRACK_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [TRACK_W-1:0]  ram_rd_data;

    logic                in_beat;
    logic                out_beat;
    logic                in_slot_ok;
    logic                occupied;
    logic                is_touch;
    logic                all_mode;
    logic                at_last_idx;
    logic                done_beat;
    logic [TRACK_W-1:0]  id_new;
    logic [TRACK_W-1:0]  next_track_next;
    kind_t               kind_next;
    logic [VALUE_W-1:0]  value;

    assign in_op   = s_tdata[1:0];
    assign in_slot = s_tdata[5:2];
    assign in_x    = s_tdata[17:6];
    assign in_y    = s_tdata[29:18];

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = (state_reg == ST_EMIT);
    assign in_beat    = s_tvalid && s_tready;
    assign out_beat   = m_tvalid && m_tready;
    assign in_slot_ok = ({1'b0, in_slot} < SLOT_LIM);
    assign is_touch   = (op_reg == OP_TOUCH);
    assign all_mode   = (op_reg == OP_RELEASE_ALL);
    assign at_last_idx = (idx_reg == LAST_IDX);

    // slot is taken when its entry was written since reset and holds an id
    assign occupied = valid_reg[idx_reg] && (ram_rd_data != '0);

    // tracking id allocation, ids cycle 1 .. TRACK_LIMIT-1
    assign id_new          = next_track_reg + TRACK_W'(1);
    assign next_track_next = (id_new == TRACK_TOP) ? '0 : id_new;

    // final beat: sync, and for release-all only once no finger is left
    assign m_tlast   = (kind_reg == EV_SYNC) && (!all_mode || count_reg == '0);
    assign done_beat = out_beat && (kind_reg == EV_SYNC);

    // ram read: slot of a new item, or the following slot during release-all
    always_comb
    begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg + AW'(1);
        if (state_reg == ST_IDLE)
        begin
            ram_rd_en   = in_beat;
            ram_rd_addr = (in_op == OP_RELEASE_ALL) ? '0 : in_slot[AW-1:0];
        end
        else if (state_reg == ST_READ)
        begin
            ram_rd_en = all_mode && !occupied && !at_last_idx;
        end
        else
        begin
            ram_rd_en = done_beat && !m_tlast;
        end
    end

    // ram write back: new id on a fresh touch, zero on a release
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_data = '0;
        if (state_reg == ST_READ)
        begin
            if (is_touch)
            begin
                ram_wr_en   = !occupied;
                ram_wr_data = id_new;
            end
            else
            begin
                ram_wr_en = occupied;
            end
        end
    end

    mtse_ram #(
        .WIDTH (TRACK_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // event order for the current slot
    always_comb
    begin
        unique case (kind_reg)
            EV_SLOT:   kind_next = (is_touch && !fresh_reg) ? EV_MTX : EV_TRACK;
            EV_TRACK:  kind_next = is_touch ? EV_MTX : (button_reg ? EV_BUTTON : EV_SYNC);
            EV_MTX:    kind_next = EV_MTY;
            EV_MTY:    kind_next = button_reg ? EV_BUTTON : (single_reg ? EV_SX : EV_SYNC);
            EV_BUTTON: kind_next = (is_touch && single_reg) ? EV_SX : EV_SYNC;
            EV_SX:     kind_next = EV_SY;
            EV_SY:     kind_next = EV_SYNC;
            default:   kind_next = EV_SYNC;
        endcase
    end

    // event value
    always_comb
    begin
        case (kind_reg) inside
            EV_SLOT:         value = VALUE_W'(idx_reg);
            EV_TRACK:        value = is_touch ? VALUE_W'(id_reg) : '1;
            EV_MTX, EV_SX:   value = VALUE_W'(x_reg);
            EV_MTY, EV_SY:   value = VALUE_W'(y_reg);
            EV_BUTTON:       value = VALUE_W'(button_reg && count_reg != '0);
            default:         value = '0;
        endcase
    end

    assign m_tdata = {(OUT_W - VALUE_W - 3)'(0), value, kind_reg};

    // sequencer state and registered item context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_TOUCH;
            idx_reg        <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            id_reg         <= '0;
            next_track_reg <= '0;
            count_reg      <= '0;
            valid_reg      <= '0;
            fresh_reg      <= 1'b0;
            button_reg     <= 1'b0;
            single_reg     <= 1'b0;
            kind_reg       <= EV_SLOT;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        op_reg  <= in_op;
                        idx_reg <= (in_op == OP_RELEASE_ALL) ? '0 : in_slot[AW-1:0];
                        x_reg   <= in_x;
                        y_reg   <= in_y;
                        if (((in_op == OP_TOUCH || in_op == OP_RELEASE) && in_slot_ok)
                            || (in_op == OP_RELEASE_ALL && count_reg != '0))
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end

                ST_READ:
                begin
                    kind_reg <= EV_SLOT;
                    if (is_touch)
                    begin
                        fresh_reg <= !occupied;
                        if (!occupied)
                        begin
                            id_reg               <= id_new;
                            next_track_reg       <= next_track_next;
                            valid_reg[idx_reg]   <= 1'b1;
                            count_reg            <= count_reg + CW'(1);
                            button_reg           <= (count_reg == '0);
                            single_reg           <= (count_reg == '0);
                        end
                        else
                        begin
                            button_reg <= 1'b0;
                            single_reg <= (count_reg == CW'(1));
                        end
                        state_reg <= ST_EMIT;
                    end
                    else if (occupied)
                    begin
                        count_reg  <= count_reg - CW'(1);
                        button_reg <= (count_reg == CW'(1));
                        single_reg <= 1'b0;
                        state_reg  <= ST_EMIT;
                    end
                    else if (all_mode && !at_last_idx)
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_EMIT:
                begin
                    if (out_beat)
                    begin
                        kind_reg <= kind_next;
                    end
                    if (done_beat)
                    begin
                        if (m_tlast)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mtse_checker.sv -----
// ============================================================================
// mtse_checker - port-level checks of the multitouch slot event generator
// Watches the stream ports over time and is bound to the top level.
// ============================================================================
`default_nettype none

module mtse_checker
    import mtse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tready,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [OUT_W-1:0]  m_tdata,
    input  wire logic              m_tlast
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // the last beat of an item is always a sync event
    a_last_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[2:0] == EV_SYNC)
        else $error("tlast on a non-sync event");

    // a slot select always opens a group and never ends an item
    a_slot_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == EV_SLOT |-> !m_tlast)
        else $error("tlast on a slot select");

    // no new item is taken while events are still being delivered
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while output beat pending");

endmodule

bind multitouch_slot_event_generator mtse_checker u_mtse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ============================================================================
// tb_top - testbench of the multitouch slot event generator
// Drives touch, release and release-all records into the input stream and
// checks every event beat against a slot-table model kept here: same slot
// ids, same event order, tlast on the final beat of each record. Runs a
// directed sequence, random touch sessions under several idle and stall
// mixes, and a long output hold-off that backs the block up to its input.
// ============================================================================
module tb_top
    import mtse_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS           = 10;
    localparam int TRACK_LIMIT     = 65535;
    localparam int ITEM_W          = OP_W + SLOT_W + 2 * COORD_W;
    localparam int MAX_REPORTS     = 10;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_CYCLES     = 150;
    localparam int LINGER_CYCLES   = 32;
    localparam int SESSION_ITEMS   = 24;

    localparam logic [OP_W-1:0]    OP_UNUSED   = 2'd3;
    localparam logic [VALUE_W-1:0] RELEASED_ID = '1;

    // one input record, op in the lowest bits as on s_tdata
    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic [SLOT_W-1:0]  slot;
        logic [OP_W-1:0]    op;
    } touch_item_t;

    typedef struct {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } slot_event_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;     // op, slot, x, y, zero pad
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;           // event_kind, event_value, zero pad
    logic              m_tlast;

    // model of the slot table
    logic [TRACK_W-1:0] track_of_slot [SLOTS] = '{default: '0};
    logic [TRACK_W-1:0] track_counter = '0;
    int unsigned        fingers_down  = 0;

    slot_event_t record_events[$];
    slot_event_t pending_slot_events[$];

    int unsigned send_idle_pct   = 0;
    int unsigned stall_pct       = 0;
    int unsigned items_taken     = 0;
    int unsigned last_item_count = 0;
    int unsigned mismatches      = 0;
    int unsigned quiet_cycles    = 0;
    int unsigned hold_left       = 0;
    logic        hold_request    = 1'b0;

    multitouch_slot_event_generator #(
        .SLOTS       (SLOTS),
        .TRACK_LIMIT (TRACK_LIMIT)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // slot table model
    // ------------------------------------------------------------------
    function automatic void add_event(kind_t kind, logic [VALUE_W-1:0] value);
        slot_event_t ev;
        ev.kind  = kind;
        ev.value = value;
        ev.last  = 1'b0;
        record_events.push_back(ev);
    endfunction

    function automatic void release_slot(int s);
        logic was_down;
        if (track_of_slot[s] == '0)
            return;
        was_down = (fingers_down != 0);
        track_of_slot[s] = '0;
        if (fingers_down != 0)
            fingers_down--;
        add_event(EV_SLOT, VALUE_W'(s));
        add_event(EV_TRACK, RELEASED_ID);
        if (was_down != (fingers_down != 0))
            add_event(EV_BUTTON, VALUE_W'(fingers_down != 0));
        add_event(EV_SYNC, '0);
    endfunction

    function automatic void touch_slot(int s, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        logic was_down;
        logic fresh;
        was_down = (fingers_down != 0);
        fresh    = (track_of_slot[s] == '0);
        // new finger takes the next id, ids wrap within 1 .. TRACK_LIMIT-1
        if (fresh)
        begin
            track_of_slot[s] = track_counter + 1'b1;
            track_counter = TRACK_W'((32'(track_counter) + 1) % (TRACK_LIMIT - 1));
            fingers_down++;
        end
        add_event(EV_SLOT, VALUE_W'(s));
        if (fresh)
            add_event(EV_TRACK, VALUE_W'(track_of_slot[s]));
        add_event(EV_MTX, VALUE_W'(x));
        add_event(EV_MTY, VALUE_W'(y));
        if (was_down != (fingers_down != 0))
            add_event(EV_BUTTON, VALUE_W'(fingers_down != 0));
        if (fingers_down == 1)
        begin
            add_event(EV_SX, VALUE_W'(x));
            add_event(EV_SY, VALUE_W'(y));
        end
        add_event(EV_SYNC, '0);
    endfunction

    function automatic void predict_touch_events(touch_item_t item);
        record_events.delete();
        case (item.op)
            OP_TOUCH:
                if (item.slot < SLOTS)
                    touch_slot(item.slot, item.x, item.y);
            OP_RELEASE:
                if (item.slot < SLOTS)
                    release_slot(item.slot);
            OP_RELEASE_ALL:
                for (int s = 0; s < SLOTS; s++)
                    release_slot(s);
            default: ;
        endcase
        if (record_events.size() > 0)
            record_events[record_events.size() - 1].last = 1'b1;
        last_item_count = record_events.size();
        foreach (record_events[i])
            pending_slot_events.push_back(record_events[i]);
    endfunction

    // ------------------------------------------------------------------
    // beat monitor: predicts on input beats, checks output beats
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : beat_monitor
        slot_event_t        want;
        kind_t              got_kind;
        logic [VALUE_W-1:0] got_value;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_touch_events(touch_item_t'(s_tdata[ITEM_W-1:0]));
                items_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                got_kind  = kind_t'(m_tdata[2:0]);
                got_value = m_tdata[3 +: VALUE_W];
                if (pending_slot_events.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected event beat: kind %0d value %05h last %0b",
                                 got_kind, got_value, m_tlast);
                end
                else
                begin
                    want = pending_slot_events.pop_front();
                    if (got_kind !== want.kind || got_value !== want.value ||
                        m_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: want %s %05h last %0b, got %0d %05h last %0b",
                                     want.kind.name(), want.value, want.last,
                                     got_kind, got_value, m_tlast);
                    end
                end
            end
            // watchdog on cycles with no beat on either side
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL multitouch_slot_event_generator");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // output side: random stalls, or a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    function automatic touch_item_t make_item(logic [OP_W-1:0] op, int slot, int x, int y);
        touch_item_t item;
        item.op   = op;
        item.slot = SLOT_W'(slot);
        item.x    = COORD_W'(x);
        item.y    = COORD_W'(y);
        return item;
    endfunction

    // mostly well-formed sessions on valid slots, some noise
    function automatic touch_item_t random_item();
        touch_item_t item;
        int unsigned pick;
        pick      = $urandom_range(99);
        item.x    = COORD_W'($urandom);
        item.y    = COORD_W'($urandom);
        item.slot = SLOT_W'($urandom_range(SLOTS - 1));
        if (pick < 55)
            item.op = OP_TOUCH;
        else if (pick < 75)
            item.op = OP_RELEASE;
        else if (pick < 80)
        begin
            item.op   = OP_RELEASE_ALL;
            item.slot = SLOT_W'($urandom);
        end
        else if (pick < 90)
        begin
            item.op   = pick[0] ? OP_TOUCH : OP_RELEASE;
            item.slot = SLOT_W'($urandom_range(15, SLOTS));
        end
        else
        begin
            item.op   = OP_UNUSED;
            item.slot = SLOT_W'($urandom);
        end
        return item;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    // is taken, tvalid left high so the next call can follow seamlessly
    task automatic send_item(touch_item_t item);
        int unsigned seen;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        seen = items_taken;
        s_tdata  <= {{(IN_W - ITEM_W){1'b0}}, item};
        s_tvalid <= 1'b1;
        do
            @(negedge clk);
        while (items_taken == seen);
    endtask

    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (pending_slot_events.size() != 0)
            @(negedge clk);
        repeat (LINGER_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_sequences();
        send_idle_pct = 0;
        stall_pct     = 0;
        // first finger, then a move to the far corner
        send_item(make_item(OP_TOUCH, 0, 0, 0));
        send_item(make_item(OP_TOUCH, 0, 4095, 4095));
        // second finger on the top slot, no single-touch beats
        send_item(make_item(OP_TOUCH, SLOTS - 1, 'hAAA, 'h555));
        // slots out of range and the unused op are dropped
        send_item(make_item(OP_TOUCH, SLOTS, 100, 200));
        send_item(make_item(OP_TOUCH, 15, 4095, 0));
        send_item(make_item(OP_RELEASE, 0, 0, 0));
        // release of a slot already free
        send_item(make_item(OP_RELEASE, 0, 0, 0));
        send_item(make_item(OP_RELEASE, 12, 0, 0));
        send_item(make_item(OP_UNUSED, 5, 1, 1));
        // back to one finger, then button up
        send_item(make_item(OP_TOUCH, SLOTS - 1, 'h555, 'hAAA));
        send_item(make_item(OP_RELEASE, SLOTS - 1, 0, 0));
        // release-all with nothing down
        send_item(make_item(OP_RELEASE_ALL, 0, 0, 0));
        // every slot down, then release-all gives the longest record
        for (int s = 0; s < SLOTS; s++)
            send_item(make_item(OP_TOUCH, s, s * 400, 4095 - s * 400));
        send_item(make_item(OP_RELEASE_ALL, 15, 0, 0));
        finish_phase();
    endtask

    task automatic test_random_sessions(int unsigned send_pct, int unsigned recv_pct);
        int counted;
        counted       = 0;
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        while (counted < SESSION_ITEMS)
        begin
            send_item(random_item());
            if (last_item_count > 0)
                counted++;
        end
        finish_phase();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 1'b1;
        // sink holds off while records keep coming, input must stall
        for (int i = 0; i < SLOTS; i++)
            send_item(make_item(OP_TOUCH, i, $urandom, $urandom));
        repeat (10) send_item(random_item());
        finish_phase();
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_sequences();
        test_random_sessions(0, 0);
        test_random_sessions(79, 0);
        test_random_sessions(0, 79);
        test_random_sessions(22, 22);
        test_output_backpressure();

        if (mismatches == 0 && pending_slot_events.size() == 0)
            $display("PASS multitouch_slot_event_generator");
        else
            $display("FAIL multitouch_slot_event_generator");
        $finish;
    end

endmodule
